@@ hw/rtl/sacld_pkg.sv @@
package sacld_pkg;

  localparam int ADDR_W = 64;
  localparam int SETS   = 64;
  localparam int WAYS   = 4;
  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int CNT_W  = $clog2(WAYS);

  typedef logic [SET_W-1:0] set_idx_t;
  typedef logic [WAY_W-1:0] way_idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MRU = cnt_t'(WAYS - 1);

endpackage

@@ hw/rtl/sacld_ram.sv @@
module sacld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/set_assoc_cache_lru_directory.sv @@
// channel | direction | handshake           | fields
// request | in        | in_valid / in_stall   | address
// result  | out       | out_valid / out_stall | hit, way, set_index, replaced_valid
//
// One request per cycle while no result stalls; lookup results are registered.
// Rate is set by the read-modify-write of a set's row, with a
// bypass from the row written in the previous cycle.
// Reset clears all valid bits at once; no clearing pass.
// A stalled result holds the lookup stage, which then stalls requests.
module set_assoc_cache_lru_directory
  import sacld_pkg::*;
#(
  parameter int LINE_OFFSET_BITS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output way_idx_t          way,
  output set_idx_t          set_index,
  output logic              replaced_valid
);

  localparam int TAG_W = ADDR_W - LINE_OFFSET_BITS - SET_W;

  logic                    in_accept;
  logic                    fire;
  set_idx_t                in_set;
  logic [TAG_W-1:0]        in_tag;

  logic                    s1_valid;
  logic                    s1_fwd;
  set_idx_t                s1_set;
  logic [TAG_W-1:0]        s1_tag;

  logic [WAYS*TAG_W-1:0]   ram_tags;
  logic [WAYS*CNT_W-1:0]   ram_cnts;
  logic [WAYS*TAG_W-1:0]   fwd_tags;
  logic [WAYS*CNT_W-1:0]   fwd_cnts;
  logic [WAYS*TAG_W-1:0]   tags_next;
  logic [WAYS*CNT_W-1:0]   cnts_next;

  logic [WAYS-1:0]         line_valid [SETS];
  logic [WAYS-1:0]         vrow;
  logic [WAYS-1:0]         vrow_next;

  logic                    hit_next;
  logic                    evict_next;
  way_idx_t                sel;

  assign in_set    = address[LINE_OFFSET_BITS +: SET_W];
  assign in_tag    = address[ADDR_W-1 -: TAG_W];
  assign fire      = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !fire;
  assign in_accept = in_valid && !in_stall;

  sacld_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (s1_set),
    .wdata (tags_next),
    .re    (in_accept),
    .raddr (in_set),
    .rdata (ram_tags)
  );

  sacld_ram #(.WIDTH(WAYS*CNT_W), .DEPTH(SETS)) u_cnt_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (s1_set),
    .wdata (cnts_next),
    .re    (in_accept),
    .raddr (in_set),
    .rdata (ram_cnts)
  );

  assign vrow = line_valid[s1_set];

  always_comb begin
    logic [TAG_W-1:0] tag_a [WAYS];
    cnt_t             cnt_a [WAYS];
    logic [WAYS*TAG_W-1:0] cur_tags;
    logic [WAYS*CNT_W-1:0] cur_cnts;
    way_idx_t         hit_way;
    way_idx_t         empty_way;
    way_idx_t         victim;
    logic             any_empty;
    cnt_t             old_cnt;

    cur_tags  = s1_fwd ? fwd_tags : ram_tags;
    cur_cnts  = s1_fwd ? fwd_cnts : ram_cnts;
    hit_next  = 1'b0;
    hit_way   = '0;
    any_empty = 1'b0;
    empty_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      tag_a[w] = cur_tags[w*TAG_W +: TAG_W];
      cnt_a[w] = vrow[w] ? cur_cnts[w*CNT_W +: CNT_W] : '0;
    end
    // descending scans so the lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && tag_a[w] == s1_tag) begin
        hit_next = 1'b1;
        hit_way  = way_idx_t'(w);
      end
      if (!vrow[w]) begin
        any_empty = 1'b1;
        empty_way = way_idx_t'(w);
      end
    end
    victim = way_idx_t'(WAYS - 1);
    for (int w = 0; w < WAYS; w++) begin
      if (cnt_a[w] < cnt_a[victim]) begin
        victim = way_idx_t'(w);
      end
    end
    sel        = hit_next ? hit_way : (any_empty ? empty_way : victim);
    evict_next = !hit_next && !any_empty;
    old_cnt    = cnt_a[sel];
    vrow_next  = vrow;
    vrow_next[sel] = 1'b1;
    for (int w = 0; w < WAYS; w++) begin
      if (way_idx_t'(w) == sel) begin
        cnts_next[w*CNT_W +: CNT_W] = CNT_MRU;
        tags_next[w*TAG_W +: TAG_W] = hit_next ? tag_a[w] : s1_tag;
      end else begin
        if (vrow[w] && cnt_a[w] != '0 && cnt_a[w] > old_cnt) begin
          cnts_next[w*CNT_W +: CNT_W] = cnt_t'(cnt_a[w] - 1'b1);
        end else begin
          cnts_next[w*CNT_W +: CNT_W] = cnt_a[w];
        end
        tags_next[w*TAG_W +: TAG_W] = tag_a[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SETS; i++) begin
        line_valid[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        line_valid[s1_set] <= vrow_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tag <= in_tag;
      s1_set <= in_set;
      s1_fwd <= fire && (s1_set == in_set);
    end
    if (fire) begin
      fwd_tags       <= tags_next;
      fwd_cnts       <= cnts_next;
      hit            <= hit_next;
      way            <= sel;
      set_index      <= s1_set;
      replaced_valid <= evict_next;
    end
  end

endmodule

@@ hw/rtl/sacld_checker.sv @@
module sacld_checker
  import sacld_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input logic     hit,
  input way_idx_t way,
  input set_idx_t set_index,
  input logic     replaced_valid
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !replaced_valid)
    else $error("eviction reported on a hit");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(way)
      && $stable(set_index) && $stable(replaced_valid))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_directory sacld_checker u_sacld_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .hit            (hit),
  .way            (way),
  .set_index      (set_index),
  .replaced_valid (replaced_valid)
);
